### rtl/cli_pkg.sv
// Shared types, constants and name tables for the command line parser.
package cli_pkg;

  localparam int SYM_W       = 8;
  localparam int NUM_W       = 7;
  localparam int VAL_W       = 16;
  localparam int CODE_W      = 3;
  localparam int NAME_SLOTS  = 8;   // one slot per match position value
  localparam int QUEUE_DEPTH = 2;

  localparam logic [SYM_W-1:0] CH_NUL  = 8'h00;
  localparam logic [SYM_W-1:0] CH_DOT  = 8'h2E;
  localparam logic [SYM_W-1:0] CH_ZERO = 8'h30;
  localparam logic [SYM_W-1:0] CH_NINE = 8'h39;
  localparam logic [SYM_W-1:0] CH_PINA = 8'h61;
  localparam logic [SYM_W-1:0] CH_PINH = 8'h68;

  localparam logic [2:0] SUB_LEN = 3'd6;

  typedef enum logic [CODE_W-1:0] {
    CMD_INVALID      = 3'd0,
    CMD_INFO         = 3'd1,
    CMD_GPIO         = 3'd2,
    CMD_ADC_SETPSC   = 3'd3,
    CMD_ADC_GETVAL   = 3'd4,
    CMD_TIMER_SETPSC = 3'd5,
    CMD_TIMER_GETPSC = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    GRP_ADC   = 2'd0,
    GRP_TIMER = 2'd1,
    GRP_INFO  = 2'd2,
    GRP_GPIO  = 2'd3
  } grp_t;

  // Classified byte handed from the front to the back.
  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             is_end;
    logic             is_dot;
    logic             is_digit;
    logic             is_pin;
    logic [3:0]       digit;
  } sym_item_t;

  // Group names, zero padded; a zero never matches since the line ends on it.
  localparam logic [SYM_W-1:0] GRP_NAME [4][NAME_SLOTS] = '{
    '{"a", "d", "c", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"t", "i", "m", "e",   "r",   8'h00, 8'h00, 8'h00},
    '{"i", "n", "f", "o",   8'h00, 8'h00, 8'h00, 8'h00},
    '{"g", "p", "i", "o",   8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam logic [2:0] GRP_LEN [4] = '{3'd3, 3'd5, 3'd4, 3'd4};

  // Subcommands per adc/timer; index 0 takes a value, index 1 does not.
  localparam logic [SYM_W-1:0] SUB_NAME [2][2][NAME_SLOTS] = '{
    '{'{"s", "e", "t", "p", "s", "c", 8'h00, 8'h00},
      '{"g", "e", "t", "v", "a", "l", 8'h00, 8'h00}},
    '{'{"s", "e", "t", "p", "s", "c", 8'h00, 8'h00},
      '{"g", "e", "t", "p", "s", "c", 8'h00, 8'h00}}
  };

endpackage

### rtl/cli_if.sv
// Valid/ready channel interfaces for the command line parser.
interface cli_sym_if;
  logic                      valid;
  logic                      ready;
  logic [cli_pkg::SYM_W-1:0] symbol;

  modport source (output valid, output symbol, input ready);
  modport sink   (input valid, input symbol, output ready);
endinterface

interface cli_item_if;
  logic               valid;
  logic               ready;
  cli_pkg::sym_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface cli_res_if;
  logic                       valid;
  logic                       ready;
  logic [cli_pkg::CODE_W-1:0] command_code;
  logic [cli_pkg::NUM_W-1:0]  number_field;
  logic [cli_pkg::VAL_W-1:0]  value_field;

  modport source (output valid, output command_code, output number_field,
                  output value_field, input ready);
  modport sink   (input valid, input command_code, input number_field,
                  input value_field, output ready);
endinterface

### rtl/cli_front.sv
// Front stage: takes input bytes and registers them with their character class.
module cli_front (
  input  logic clk,
  input  logic rst,
  cli_sym_if.sink    symbols,
  cli_item_if.source items
);
  import cli_pkg::*;

  logic      vld;
  sym_item_t item;
  sym_item_t item_next;

  assign symbols.ready = !vld || items.ready;
  assign items.valid   = vld;
  assign items.item    = item;

  always_comb begin
    item_next.symbol   = symbols.symbol;
    item_next.is_end   = (symbols.symbol == CH_NUL);
    item_next.is_dot   = (symbols.symbol == CH_DOT);
    item_next.is_digit = (symbols.symbol >= CH_ZERO) && (symbols.symbol <= CH_NINE);
    item_next.is_pin   = (symbols.symbol >= CH_PINA) && (symbols.symbol <= CH_PINH);
    item_next.digit    = symbols.symbol[3:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (symbols.ready) begin
      vld <= symbols.valid;
    end
    if (symbols.valid && symbols.ready) begin
      item <= item_next;
    end
  end

endmodule

### rtl/cli_queue.sv
// Short FIFO of classified bytes between front and back.
module cli_queue (
  input  logic clk,
  input  logic rst,
  cli_item_if.sink   wr,
  cli_item_if.source rd
);
  import cli_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  sym_item_t        slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign wr.ready = (count != CNT_W'(QUEUE_DEPTH));
  assign rd.valid = (count != '0);
  assign rd.item  = slots[rd_ptr];
  assign push     = wr.valid && wr.ready;
  assign pop      = rd.valid && rd.ready;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop)  rd_ptr <= ptr_inc(rd_ptr);
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
    if (push) begin
      slots[wr_ptr] <= wr.item;
    end
  end

endmodule

### rtl/cli_back.sv
// Back stage: grammar state machine and registered result output.
module cli_back (
  input  logic clk,
  input  logic rst,
  cli_item_if.sink  items,
  cli_res_if.source results
);
  import cli_pkg::*;

  typedef enum logic [2:0] {
    PH_GROUP,
    PH_NUM,
    PH_SUB,
    PH_VAL,
    PH_ERROR
  } phase_t;

  phase_t           phase,      phase_next;
  logic [3:0]       grp_cand,   grp_cand_next;
  logic [2:0]       match_pos,  match_pos_next;
  grp_t             sel_grp,    sel_grp_next;
  logic [1:0]       sub_cand,   sub_cand_next;
  logic [2:0]       digit_cnt,  digit_cnt_next;
  logic [NUM_W-1:0] num_acc,    num_acc_next;
  logic [VAL_W-1:0] val_acc,    val_acc_next;

  logic             out_vld;
  cmd_t             out_code;
  logic [NUM_W-1:0] out_num;
  logic [VAL_W-1:0] out_val;

  logic             pop;
  sym_item_t        it;
  cmd_t             code;
  logic [3:0]       grp_hit;
  logic [1:0]       sub_hit;
  logic             grp_found;
  grp_t             grp_pick;
  logic [VAL_W-1:0] val_times10;
  logic [NUM_W-1:0] num_times10;

  assign it    = items.item;
  // Only a line end needs the output slot.
  assign items.ready = !it.is_end || !out_vld || results.ready;
  assign pop   = items.valid && items.ready;

  assign results.valid        = out_vld;
  assign results.command_code = out_code;
  assign results.number_field = out_num;
  assign results.value_field  = out_val;

  assign val_times10 = {val_acc[VAL_W-4:0], 3'b000} + {val_acc[VAL_W-2:0], 1'b0};
  assign num_times10 = {num_acc[NUM_W-4:0], 3'b000} + {num_acc[NUM_W-2:0], 1'b0};

  // Name matching against the constant tables; elements are independent.
  always_comb begin
    for (int g = 0; g < 4; g++) begin
      grp_hit[g] = grp_cand[g] && (GRP_NAME[g][match_pos] == it.symbol);
    end
    for (int s = 0; s < 2; s++) begin
      sub_hit[s] = sub_cand[s] &&
                   (SUB_NAME[sel_grp == GRP_TIMER][s][match_pos] == it.symbol);
    end
    grp_found = 1'b0;
    grp_pick  = GRP_ADC;
    for (int g = 3; g >= 0; g--) begin
      if (grp_cand[g] && (GRP_LEN[g] == match_pos)) begin
        grp_found = 1'b1;
        grp_pick  = grp_t'(g[1:0]);
      end
    end
  end

  // Result code for a line end in the current state.
  always_comb begin
    code = CMD_INVALID;
    unique case (phase)
      PH_NUM: begin
        if (sel_grp == GRP_INFO && digit_cnt != 3'd0)      code = CMD_INFO;
        else if (sel_grp == GRP_GPIO && digit_cnt == 3'd1) code = CMD_GPIO;
      end
      PH_SUB: begin
        if (match_pos == SUB_LEN && sub_cand[1]) begin
          code = (sel_grp == GRP_TIMER) ? CMD_TIMER_GETPSC : CMD_ADC_GETVAL;
        end
      end
      PH_VAL: begin
        if (digit_cnt != 3'd0) begin
          code = (sel_grp == GRP_TIMER) ? CMD_TIMER_SETPSC : CMD_ADC_SETPSC;
        end
      end
      PH_GROUP, PH_ERROR: code = CMD_INVALID;
      default: code = CMD_INVALID;
    endcase
  end

  always_comb begin
    phase_next     = phase;
    grp_cand_next  = grp_cand;
    match_pos_next = match_pos;
    sel_grp_next   = sel_grp;
    sub_cand_next  = sub_cand;
    digit_cnt_next = digit_cnt;
    num_acc_next   = num_acc;
    val_acc_next   = val_acc;

    if (pop && it.is_end) begin
      phase_next     = PH_GROUP;
      grp_cand_next  = 4'hF;
      match_pos_next = '0;
      sel_grp_next   = GRP_ADC;
      sub_cand_next  = 2'b11;
      digit_cnt_next = '0;
      num_acc_next   = '0;
      val_acc_next   = '0;
    end else if (pop) begin
      unique case (phase)
        PH_GROUP: begin
          if (it.is_dot) begin
            if (grp_found) begin
              sel_grp_next   = grp_pick;
              phase_next     = PH_NUM;
              digit_cnt_next = '0;
              num_acc_next   = '0;
            end else begin
              phase_next = PH_ERROR;
            end
          end else begin
            grp_cand_next = grp_hit;
            if (grp_hit == '0) phase_next = PH_ERROR;
            else               match_pos_next = match_pos + 1'b1;
          end
        end
        PH_NUM: begin
          if (sel_grp == GRP_GPIO) begin
            if (digit_cnt == 3'd0 && it.is_pin) begin
              num_acc_next   = it.symbol[NUM_W-1:0];
              digit_cnt_next = 3'd1;
            end else begin
              phase_next = PH_ERROR;
            end
          end else if (it.is_dot && (sel_grp == GRP_ADC || sel_grp == GRP_TIMER)) begin
            phase_next     = PH_SUB;
            match_pos_next = '0;
            sub_cand_next  = 2'b11;
          end else if (it.is_digit && digit_cnt < 3'd2 &&
                       !(digit_cnt == 3'd0 && it.digit == 4'd0)) begin
            num_acc_next   = num_times10 + NUM_W'(it.digit);
            digit_cnt_next = digit_cnt + 1'b1;
          end else begin
            phase_next = PH_ERROR;
          end
        end
        PH_SUB: begin
          if (it.is_dot) begin
            if (match_pos == SUB_LEN && sub_cand[0]) begin
              phase_next     = PH_VAL;
              digit_cnt_next = '0;
              val_acc_next   = '0;
            end else begin
              phase_next = PH_ERROR;
            end
          end else begin
            sub_cand_next = sub_hit;
            if (sub_hit == '0) phase_next = PH_ERROR;
            else               match_pos_next = match_pos + 1'b1;
          end
        end
        PH_VAL: begin
          if (it.is_digit && digit_cnt < 3'd5) begin
            val_acc_next   = val_times10 + VAL_W'(it.digit);
            digit_cnt_next = digit_cnt + 1'b1;
          end else begin
            phase_next = PH_ERROR;
          end
        end
        PH_ERROR: phase_next = PH_ERROR;
        default:  phase_next = PH_ERROR;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_GROUP;
      grp_cand  <= 4'hF;
      match_pos <= '0;
      sel_grp   <= GRP_ADC;
      sub_cand  <= 2'b11;
      digit_cnt <= '0;
      num_acc   <= '0;
      val_acc   <= '0;
      out_vld   <= 1'b0;
    end else begin
      phase     <= phase_next;
      grp_cand  <= grp_cand_next;
      match_pos <= match_pos_next;
      sel_grp   <= sel_grp_next;
      sub_cand  <= sub_cand_next;
      digit_cnt <= digit_cnt_next;
      num_acc   <= num_acc_next;
      val_acc   <= val_acc_next;
      if (pop && it.is_end)   out_vld <= 1'b1;
      else if (results.ready) out_vld <= 1'b0;
    end
    if (pop && it.is_end) begin
      out_code <= code;
      out_num  <= (code != CMD_INVALID) ? num_acc : '0;
      out_val  <= (code == CMD_ADC_SETPSC || code == CMD_TIMER_SETPSC) ? val_acc : '0;
    end
  end

endmodule

### rtl/cli_command_line_parser.sv
// Top level of the command line parser: front classifier, queue, grammar back end.
// Throughput: one byte transfer per cycle, sustained, on both sides of the queue while
//   the back end is not stalled. A zero byte raises results.valid via the front register,
//   queue slot and back-end output register; the result transfer can follow.
// Nonzero bytes produce no result; each zero byte produces exactly one result.
// Reset (rst, synchronous, active high) empties the pipeline and queue and puts
//   the grammar state back to "expect group name".
module cli_command_line_parser (
  input  logic clk,
  input  logic rst,
  cli_sym_if.sink   symbols,
  cli_res_if.source results
);
  import cli_pkg::*;

  // front -> queue and queue -> back carry classified bytes
  cli_item_if f2q ();
  cli_item_if q2b ();

  // Front: accepts one byte per cycle while the queue takes it, and tags its character class.
  cli_front u_front (
    .clk     (clk),
    .rst     (rst),
    .symbols (symbols),
    .items   (f2q.source)
  );

  // Queue decouples the front from a back end stalled on a held result.
  cli_queue u_queue (
    .clk (clk),
    .rst (rst),
    .wr  (f2q.sink),
    .rd  (q2b.source)
  );

  // Back end: walks the grammar; a zero byte loads the result register.
  cli_back u_back (
    .clk     (clk),
    .rst     (rst),
    .items   (q2b.sink),
    .results (results)
  );

  // An invalid line reports zero number and value.
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.command_code == CMD_INVALID |->
      results.number_field == '0 && results.value_field == '0)
    else $error("invalid result carries nonzero fields");

  // A line end taken by the back end shows a result on the next cycle.
  a_end_gives_result: assert property (@(posedge clk) disable iff (rst)
    q2b.valid && q2b.ready && q2b.item.is_end |=> results.valid)
    else $error("line end did not produce a result");

  // A gpio result holds a pin letter a..h.
  a_gpio_letter: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.command_code == CMD_GPIO |->
      results.number_field >= NUM_W'(CH_PINA) && results.number_field <= NUM_W'(CH_PINH))
    else $error("gpio result without pin letter");

  // Only setpsc commands carry a value.
  a_value_only_setpsc: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.value_field != '0 |->
      results.command_code == CMD_ADC_SETPSC || results.command_code == CMD_TIMER_SETPSC)
    else $error("value on a command that takes none");

endmodule
